// ----- hw/rtl/text_console_writer_defines.svh -----
// shared assertion macros for the text console writer
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define TCW_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define TCW_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hw/rtl/tcw_pkg.sv -----
package tcw_pkg;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // special characters and blank cells
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_RESET  = {ATTR_RESET, CH_SPACE};

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } request_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row_now;
        logic [COL_W-1:0]  cursor_col_now;
        logic [CELL_W-1:0] cell_value;
    } result_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COPY,
        ST_FILL,
        ST_RESPOND
    } state_t;

endpackage

// ----- hw/rtl/tcw_ram.sv -----
module tcw_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/text_console_writer.sv -----
// text console writer: a ROWS x COLUMNS screen of 16-bit cells
// (attribute high byte, character low byte) with a cursor.
// request channel: a request is taken on a clock edge with start high and
// busy low; op selects put character, clear screen or read one cell.
// result channel: done is high for exactly one cycle with result holding
// the cursor after the request and, for a read, the cell; the receiver
// cannot stall, so every result is taken in that cycle.
// config channel: cfg_data is the text attribute, written on cfg_valid
// (cfg_ready is always high); write it only while the block is idle.
// a put without a scroll, a read or an unused op is accepted in idle and answered
// from the result state; the cell memory has a registered read.
// no new request is taken before the result; busy is high in the result cycle.
// a put that moves past the last row scrolls: a copy sweep of one cell per
// cycle plus a blank fill of the bottom row.
// clear fills every cell, one per cycle.
// after reset the block runs a clearing pass over all ROWS*COLUMNS cells
// (2000 at 80x25), writing blank cells with attribute 7; busy stays high.
`include "text_console_writer_defines.svh"

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  request_t          request,
    output logic              done,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ATTR_W-1:0] cfg_data
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ATTR_W-1:0]  attr_reg;
    logic [CELL_W-1:0]  fill_val_reg, fill_val_next;
    logic               cell_sel_reg, cell_sel_next;

    logic               accept;
    logic               is_bs, is_nl, col_wrap, last_row, scroll_req, read_ok;
    logic [AW-1:0]      cur_addr, rd_addr;
    logic [CELL_W-1:0]  blank_cell;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    // cell store
    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS),
        .ADDR_W(AW)
    ) u_cells (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // request decode
    assign accept     = start && !busy;
    assign is_bs      = request.char_code == CH_BACKSPACE;
    assign is_nl      = request.char_code == CH_NEWLINE;
    assign col_wrap   = int'(col_reg) == COLUMNS - 1;
    assign last_row   = int'(row_reg) == ROWS - 1;
    assign scroll_req = (request.op == OP_PUT) && last_row && (is_nl || (!is_bs && col_wrap));
    assign read_ok    = (int'(request.read_row) < ROWS) && (int'(request.read_col) < COLUMNS);
    assign cur_addr   = AW'(int'(row_reg) * COLUMNS + int'(col_reg));
    assign rd_addr    = AW'(int'(request.read_row) * COLUMNS + int'(request.read_col));
    assign blank_cell = {attr_reg, CH_SPACE};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.op == OP_CLEAR)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (scroll_req)
                    begin
                        state_next = ST_COPY;
                    end
                    else
                    begin
                        state_next = ST_RESPOND;
                    end
                end
            end
            ST_COPY:
            begin
                if (cnt_reg == CNT_W'(CELLS))
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = ST_RESPOND;
                end
            end
            ST_RESPOND:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory accesses, cursor and sweep counter
    always_comb
    begin
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        fill_val_next = fill_val_reg;
        cell_sel_next = cell_sel_reg;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg[AW-1:0];
        ram_wdata     = fill_val_reg;
        ram_raddr     = cnt_reg[AW-1:0];
        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = BLANK_RESET;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    cnt_next = '0;
                end
            end
            ST_IDLE:
            begin
                ram_raddr = rd_addr;
                if (accept)
                begin
                    cell_sel_next = 1'b0;
                    fill_val_next = blank_cell;
                    case (request.op)
                        OP_PUT:
                        begin
                            if (is_bs)
                            begin
                                // backspace at column 0 does nothing
                                if (col_reg != '0)
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = cur_addr - 1'b1;
                                    ram_wdata = blank_cell;
                                    col_next  = col_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                if (!is_nl)
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = cur_addr;
                                    ram_wdata = {attr_reg, request.char_code};
                                    col_next  = col_reg + 1'b1;
                                end
                                // newline or end of row
                                if (is_nl || col_wrap)
                                begin
                                    col_next = '0;
                                    if (last_row)
                                    begin
                                        cnt_next = CNT_W'(COLUMNS);
                                    end
                                    else
                                    begin
                                        row_next = row_reg + 1'b1;
                                    end
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            row_next = '0;
                            col_next = '0;
                            cnt_next = '0;
                        end
                        OP_READ:
                        begin
                            cell_sel_next = read_ok;
                        end
                        default:
                        begin
                            cell_sel_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                // read one row ahead, write the cell read last cycle
                ram_raddr = cnt_reg[AW-1:0];
                if (cnt_reg > CNT_W'(COLUMNS))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(cnt_reg - CNT_W'(COLUMNS) - 1'b1);
                    ram_wdata = ram_rdata;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CELLS))
                begin
                    cnt_next = CNT_W'(CELLS - COLUMNS);
                end
            end
            ST_FILL:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_RESPOND:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            cnt_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            attr_reg     <= ATTR_RESET;
            cell_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            cell_sel_reg <= cell_sel_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    // blank value for clear and scroll
    always_ff @(posedge clk)
    begin
        fill_val_reg <= fill_val_next;
    end

    // handshake and result
    assign cfg_ready             = 1'b1;
    assign busy                  = state_reg != ST_IDLE;
    assign done                  = state_reg == ST_RESPOND;
    assign result.cursor_row_now = row_reg;
    assign result.cursor_col_now = col_reg;
    assign result.cell_value     = cell_sel_reg ? ram_rdata : '0;

    // checks
    `TCW_ASSERT_SAME(a_col_range, 1'b1, int'(col_reg) < COLUMNS, "cursor column off screen")
    `TCW_ASSERT_SAME(a_row_range, 1'b1, int'(row_reg) < ROWS, "cursor row off screen")
    `TCW_ASSERT_NEXT(a_accept_busy, accept, busy, "request accepted but block not busy")
    `TCW_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `TCW_ASSERT_NEXT(a_clear_fills, accept && (request.op == OP_CLEAR),
        (state_reg == ST_FILL) && (cnt_reg == '0), "clear did not start a fill")

endmodule

// ----- test/tb_text_console_writer.sv -----
module tb_text_console_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = ROWS * COLUMNS;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS = 150;
    localparam int PHASES = 5;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    request_t request = '0;
    logic done;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ATTR_W-1:0] cfg_data = '0;

    // shadow copy of the screen, cursor and attribute
    logic [CELL_W-1:0] screen_shadow [CELLS];
    int unsigned shadow_row;
    int unsigned shadow_col;
    logic [ATTR_W-1:0] attr_shadow;

    result_t expected_results [$];
    result_t oldest_result;
    int error_count = 0;
    int quiet_cycles = 0;
    bit start_driven = 1'b0;

    text_console_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [CELL_W-1:0] blank_cell();
        return {attr_shadow, CH_SPACE};
    endfunction

    // move to the start of the next row, scrolling up at the bottom
    function automatic void advance_row();
        shadow_col = 0;
        if (shadow_row + 1 < ROWS)
        begin
            shadow_row++;
        end
        else
        begin
            for (int i = 0; i + COLUMNS < CELLS; i++)
                screen_shadow[i] = screen_shadow[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen_shadow[i] = blank_cell();
        end
    endfunction

    // apply one request to the shadow screen and return its result
    function automatic result_t console_predict(request_t req);
        result_t res;
        int at;
        res = '0;
        at = shadow_row * COLUMNS + shadow_col;
        case (req.op)
            OP_PUT:
            begin
                if (req.char_code == CH_BACKSPACE)
                begin
                    if (shadow_col > 0)
                    begin
                        shadow_col--;
                        screen_shadow[at - 1] = blank_cell();
                    end
                end
                else if (req.char_code == CH_NEWLINE)
                begin
                    advance_row();
                end
                else
                begin
                    screen_shadow[at] = {attr_shadow, req.char_code};
                    shadow_col++;
                    if (shadow_col >= COLUMNS)
                        advance_row();
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_shadow[i] = blank_cell();
                shadow_row = 0;
                shadow_col = 0;
            end
            OP_READ:
            begin
                if (req.read_row < ROWS && req.read_col < COLUMNS)
                    res.cell_value = screen_shadow[req.read_row * COLUMNS + req.read_col];
            end
            default:
            begin
            end
        endcase
        res.cursor_row_now = ROW_W'(shadow_row);
        res.cursor_col_now = COL_W'(shadow_col);
        return res;
    endfunction

    // request with every field random, then the op set
    function automatic request_t noisy_request(logic [OP_W-1:0] op);
        request_t req;
        req.op = op;
        req.char_code = CHAR_W'($urandom);
        req.read_row = ROW_W'($urandom);
        req.read_col = COL_W'($urandom);
        return req;
    endfunction

    // drop start, only if this side raised it
    task automatic release_start();
        if (start_driven)
        begin
            start <= 1'b0;
            start_driven = 1'b0;
        end
    endtask

    // present one request and hold it until it is taken
    task automatic send_request(request_t req);
        start <= 1'b1;
        start_driven = 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(console_predict(req));
    endtask

    task automatic put_char(logic [CHAR_W-1:0] ch);
        request_t req;
        req = noisy_request(OP_PUT);
        req.char_code = ch;
        send_request(req);
    endtask

    task automatic read_cell(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        request_t req;
        req = noisy_request(OP_READ);
        req.read_row = row;
        req.read_col = col;
        send_request(req);
    endtask

    // wait until every result is in and the block is idle
    task automatic wait_idle();
        release_start();
        do
            @(posedge clk);
        while (expected_results.size() != 0 || busy);
    endtask

    task automatic write_attribute(logic [ATTR_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        attr_shadow = value;
    endtask

    // random idle burst on the request side
    task automatic maybe_pause(bit allow);
        if (allow && $urandom_range(0, 7) == 0)
        begin
            release_start();
            repeat ($urandom_range(1, 19))
                @(posedge clk);
        end
    endtask

    function automatic logic [CHAR_W-1:0] random_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return CH_NEWLINE;
        if (roll < 20)
            return CH_BACKSPACE;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // blank screen after reset, corners and reads off the screen
    task automatic test_reset_state();
        read_cell(5'd0, 7'd0);
        read_cell(ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
        read_cell(ROW_W'(ROWS), 7'd0);
        read_cell(5'd0, COL_W'(COLUMNS));
        read_cell(5'd31, 7'd127);
    endtask

    // character byte extremes, no sign extension
    task automatic test_put_extremes();
        put_char(8'hff);
        put_char(8'h00);
        put_char(8'h80);
        put_char(8'h7f);
        read_cell(5'd0, 7'd2);
    endtask

    // backspace at column 0 is a no-op, otherwise blanks the cell
    task automatic test_backspace();
        put_char(CH_NEWLINE);
        put_char(CH_BACKSPACE);
        put_char(8'h41);
        put_char(CH_BACKSPACE);
        read_cell(5'd1, 7'd0);
    endtask

    // attribute extremes land in the high byte
    task automatic test_attribute_extremes();
        write_attribute(8'h00);
        put_char(8'h41);
        write_attribute(8'hff);
        put_char(8'h42);
        read_cell(5'd1, 7'd0);
        read_cell(5'd1, 7'd1);
    endtask

    // unused op, clear in the current attribute
    task automatic test_clear_and_unused();
        send_request(noisy_request(OP_UNUSED));
        send_request(noisy_request(OP_CLEAR));
        read_cell(ROW_W'(ROWS / 2), COL_W'(COLUMNS / 2));
        write_attribute(ATTR_RESET);
    endtask

    // mostly runs of text with reads near the cursor, some noise
    task automatic test_random_traffic();
        int count;
        int roll;
        int run_len;
        bit allow_idle;
        logic [ATTR_W-1:0] attr_value;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1: attr_value = 8'h00;
                2: attr_value = 8'hff;
                PHASES - 1: attr_value = ATTR_RESET;
                default: attr_value = ATTR_W'($urandom);
            endcase
            write_attribute(attr_value);
            allow_idle = (phase != PHASES - 1);
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                begin
                    run_len = $urandom_range(1, 12);
                    repeat (run_len)
                    begin
                        put_char(random_char());
                        count++;
                        maybe_pause(allow_idle);
                    end
                end
                else
                begin
                    if (roll < 85)
                        read_cell($urandom_range(0, 1) ? ROW_W'(shadow_row)
                                                       : ROW_W'($urandom_range(0, ROWS - 1)),
                                  COL_W'($urandom_range(0, COLUMNS - 1)));
                    else if (roll < 95)
                        send_request(noisy_request(OP_READ));
                    else if (roll < 97)
                        send_request(noisy_request(OP_CLEAR));
                    else
                        send_request(noisy_request(OP_UNUSED));
                    count++;
                    maybe_pause(allow_idle);
                end
            end
        end
    endtask

    // compare each result with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %p", $time, result);
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (result.cursor_row_now !== oldest_result.cursor_row_now)
                begin
                    error_count++;
                    $display("%0t: cursor_row_now expected %0d actual %0d", $time,
                             oldest_result.cursor_row_now, result.cursor_row_now);
                end
                if (result.cursor_col_now !== oldest_result.cursor_col_now)
                begin
                    error_count++;
                    $display("%0t: cursor_col_now expected %0d actual %0d", $time,
                             oldest_result.cursor_col_now, result.cursor_col_now);
                end
                if (result.cell_value !== oldest_result.cell_value)
                begin
                    error_count++;
                    $display("%0t: cell_value expected %h actual %h", $time,
                             oldest_result.cell_value, result.cell_value);
                end
            end
        end
    end

    // watchdog on cycles with no request, result or register write
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_text_console_writer: done, errors");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        for (int i = 0; i < CELLS; i++)
            screen_shadow[i] = BLANK_RESET;
        shadow_row = 0;
        shadow_col = 0;
        attr_shadow = ATTR_RESET;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_put_extremes();
        test_backspace();
        test_attribute_extremes();
        test_clear_and_unused();
        test_random_traffic();

        wait_idle();
        repeat (8)
            @(posedge clk);
        if (error_count == 0)
            $display("tb_text_console_writer: done, clean");
        else
            $display("tb_text_console_writer: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/text_console_writer.sv
test/tb_text_console_writer.sv
